### rtl/sa_pkg.sv
// Shared types and codes for the stack allocator with fallback.
// Used by the cell row and the top level; no dependencies.
`default_nettype none

package sa_pkg;

    localparam int ALLOC_BITS = 29;
    localparam logic [23:0] INIT_CAP_RST = 24'd4096;
    localparam logic [31:0] ALLOC_MAX = 32'h1FFF_FFFF;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_GROW  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_IN_USE   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [23:0] request_size;
        logic [23:0] free_offset;
    } t_sa_req;

    typedef struct packed {
        logic [23:0]           result_offset;
        logic                  used_fallback;
        logic [2:0]            status;
        logic [ALLOC_BITS-1:0] allocation_now;
        logic [ALLOC_BITS-1:0] peak_allocation;
        logic [23:0]           capacity_now;
    } t_sa_rsp;

    // Shift control shared by every cell of the entry row.
    typedef struct packed {
        logic push;
        logic pop;
    } t_sa_shift;

endpackage

`default_nettype wire

### rtl/sa_cell.sv
// One slot of the entry stack row; shifts down on push, up on pop.
// Depends on sa_pkg for the shift control struct.
`default_nettype none

module sa_cell #(
    parameter int W = 25
) (
    input  wire logic              i_clk,
    input  wire sa_pkg::t_sa_shift i_shift,
    input  wire logic [W-1:0]      i_above,
    input  wire logic [W-1:0]      i_below,
    output logic [W-1:0]           o_entry
);

    logic [W-1:0] r_entry;
    logic [W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_shift.push) begin
            n_entry = i_above;
        end else if (i_shift.pop) begin
            n_entry = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

### rtl/stack_allocator_with_fallback_top.sv
// Top level of the stack allocator with fallback: counters, checks and the entry row.
// Depends on sa_pkg and sa_cell.
//
// Busy never rises, so a command can be issued on every clock. The result appears on
// o_rsp with o_valid high for exactly one cycle, in the cycle after start; the receiver
// cannot stall and must take it in that cycle. The top-of-stack compare, the allocation
// add with saturation and the grow add all sit in one register stage. The entry stack is
// a row of cells whose top sits in cell 0, so a free reads only that cell. A
// configuration write reloads the region capacity at once.
`default_nettype none

module stack_allocator_with_fallback_top #(
    parameter int MAX_ENTRIES = 32,
    parameter int SIZE_BITS   = 24
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire sa_pkg::t_sa_req i_req,
    output logic                 o_valid,
    output sa_pkg::t_sa_rsp      o_rsp,
    input  wire logic            i_cfg_we,
    input  wire logic [23:0]     i_cfg_wdata
);

    localparam int CW   = SIZE_BITS;
    localparam int EW   = CW + 1;
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int AB   = sa_pkg::ALLOC_BITS;
    localparam logic [31:0] SIZE_MASK = 32'((64'd1 << SIZE_BITS) - 64'd1);

    logic [CW-1:0] r_top, n_top;
    logic [AB-1:0] r_alloc, n_alloc;
    logic [AB-1:0] r_hw, n_hw;
    logic [CW-1:0] r_cap, n_cap;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic          r_valid;
    sa_pkg::t_sa_rsp r_rsp, n_rsp;

    sa_pkg::t_sa_shift w_shift;
    logic [EW-1:0] w_ent [MAX_ENTRIES];
    logic [EW-1:0] w_new;

    logic          w_go;
    logic [CW-1:0] w_size;
    logic [CW:0]   w_end;
    logic [31:0]   w_asum;
    logic [31:0]   w_grow;
    logic [CW-1:0] w_top_size;
    logic          w_top_fb;
    logic [CW-1:0] w_base;
    logic [31:0]   w_base32;
    logic [31:0]   w_cap_cfg;

    assign w_go      = start && !busy;
    assign w_size    = CW'(({8'd0, i_req.request_size}) & SIZE_MASK);
    assign w_end     = {1'b0, r_top} + {1'b0, w_size};
    assign w_asum    = 32'(r_alloc) + 32'(w_size);
    assign w_grow    = 32'(r_hw) + 32'(r_hw >> 1);
    assign w_top_size = w_ent[0][CW-1:0];
    assign w_top_fb  = w_ent[0][CW];
    assign w_base    = (r_top >= w_top_size) ? (r_top - w_top_size) : '0;
    assign w_base32  = 32'(w_base);
    assign w_cap_cfg = ({8'd0, i_cfg_wdata}) & SIZE_MASK;

    always_comb begin
        logic [31:0] cap32;
        logic [31:0] top32;
        n_top   = r_top;
        n_alloc = r_alloc;
        n_hw    = r_hw;
        n_cap   = r_cap;
        n_cnt   = r_cnt;
        w_shift = '0;
        w_new   = {1'b0, w_size};
        n_rsp   = '0;
        n_rsp.status = sa_pkg::ST_OK;
        top32   = 32'(r_top);

        case (i_req.action)
            sa_pkg::ACT_ALLOC: begin
                if (r_cnt == CNTW'(MAX_ENTRIES)) begin
                    n_rsp.status = sa_pkg::ST_FULL;
                end else begin
                    if (w_end > {1'b0, r_cap}) begin
                        w_new[CW] = 1'b1;
                        n_rsp.used_fallback = 1'b1;
                    end else begin
                        n_rsp.result_offset = top32[23:0];
                        n_top = w_end[CW-1:0];
                    end
                    n_alloc = (w_asum > sa_pkg::ALLOC_MAX) ? AB'(sa_pkg::ALLOC_MAX)
                                                           : w_asum[AB-1:0];
                    if (n_alloc > r_hw) begin
                        n_hw = n_alloc;
                    end
                    w_shift.push = 1'b1;
                    n_cnt = r_cnt + CNTW'(1);
                end
            end
            sa_pkg::ACT_FREE: begin
                if (r_cnt == '0) begin
                    n_rsp.status = sa_pkg::ST_EMPTY;
                end else if (!w_top_fb && (w_base32[23:0] != i_req.free_offset)) begin
                    n_rsp.status = sa_pkg::ST_MISMATCH;
                end else begin
                    if (!w_top_fb) begin
                        n_top = w_base;
                    end
                    n_alloc = (32'(r_alloc) >= 32'(w_top_size))
                            ? AB'(32'(r_alloc) - 32'(w_top_size)) : '0;
                    w_shift.pop = 1'b1;
                    n_cnt = r_cnt - CNTW'(1);
                end
            end
            sa_pkg::ACT_GROW: begin
                if (r_cnt != '0) begin
                    n_rsp.status = sa_pkg::ST_IN_USE;
                end else if (32'(r_hw) > 32'(r_cap)) begin
                    n_cap = (w_grow > SIZE_MASK) ? CW'(SIZE_MASK) : CW'(w_grow);
                end
            end
            default: begin
                // unknown action: no change, status ok
            end
        endcase

        if (!w_go) begin
            n_top   = r_top;
            n_alloc = r_alloc;
            n_hw    = r_hw;
            n_cap   = r_cap;
            n_cnt   = r_cnt;
            w_shift = '0;
        end

        cap32 = 32'(n_cap);
        n_rsp.allocation_now  = n_alloc;
        n_rsp.peak_allocation = n_hw;
        n_rsp.capacity_now    = cap32[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_alloc <= '0;
            r_hw    <= '0;
            r_cap   <= CW'(({8'd0, sa_pkg::INIT_CAP_RST}) & SIZE_MASK);
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_top   <= n_top;
            r_alloc <= n_alloc;
            r_hw    <= n_hw;
            r_cnt   <= n_cnt;
            r_valid <= w_go;
            if (i_cfg_we) begin
                r_cap  <= CW'(w_cap_cfg);
            end else begin
                r_cap  <= n_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_rsp <= n_rsp;
        end
    end

    // Entry row: cell 0 holds the top entry.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [EW-1:0] w_above;
        logic [EW-1:0] w_below;
        if (g == 0) begin : g_first
            assign w_above = w_new;
        end else begin : g_mid
            assign w_above = w_ent[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_below = w_ent[g];
        end else begin : g_inner
            assign w_below = w_ent[g+1];
        end
        sa_cell #(
            .W (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_above (w_above),
            .i_below (w_below),
            .o_entry (w_ent[g])
        );
    end

    assign busy    = 1'b0;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire
